// ----- src/rv32_decode_stage_with_hazards_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef RV32_DECODE_STAGE_WITH_HAZARDS_MACROS_SVH
`define RV32_DECODE_STAGE_WITH_HAZARDS_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define RVDEC_CHK_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rvdec check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define RVDEC_CHK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rvdec check failed");

`endif

// ----- src/rvdec_pkg.sv -----
package rvdec_pkg;

	localparam int unsigned XLEN = 32;
	localparam int unsigned REG_AW = 5;
	localparam int unsigned NREGS = 1 << REG_AW;

	localparam logic [3:0] MEM_NONE = 4'd15;
	localparam logic [3:0] STORE_FLAG = 4'd8;
	localparam logic [XLEN-1:0] DEAD_VALUE = 32'h0000_dead;
	localparam logic [REG_AW-1:0] SYS_DEST = 5'h1f;
	localparam logic [XLEN-1:0] LINK_STEP = 32'd4;
	localparam logic [4:0] ALU_ADD = 5'd0;
	localparam logic [4:0] ALU_OR = 5'd6;

	// Major opcodes, instruction bits 6..2.
	localparam logic [4:0] OPC_LOAD = 5'd0;
	localparam logic [4:0] OPC_FENCE = 5'd3;
	localparam logic [4:0] OPC_OPIMM = 5'd4;
	localparam logic [4:0] OPC_AUIPC = 5'd5;
	localparam logic [4:0] OPC_STORE = 5'd8;
	localparam logic [4:0] OPC_OP = 5'd12;
	localparam logic [4:0] OPC_LUI = 5'd13;
	localparam logic [4:0] OPC_BRANCH = 5'd24;
	localparam logic [4:0] OPC_JALR = 5'd25;
	localparam logic [4:0] OPC_JAL = 5'd27;
	localparam logic [4:0] OPC_SYSTEM = 5'd28;

	// Branch funct3 codes.
	localparam logic [2:0] F3_BEQ = 3'd0;
	localparam logic [2:0] F3_BNE = 3'd1;
	localparam logic [2:0] F3_BLT = 3'd4;
	localparam logic [2:0] F3_BGE = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6;
	localparam logic [2:0] F3_BGEU = 3'd7;

	// Shift funct3 codes, where bit 30 selects the variant.
	localparam logic [2:0] F3_SLL = 3'd1;
	localparam logic [2:0] F3_SRX = 3'd5;

	typedef struct packed {
		logic              ex_write;
		logic [REG_AW-1:0] ex_reg;
		logic              mem_write;
		logic [REG_AW-1:0] mem_reg;
		logic              wb_write;
		logic [REG_AW-1:0] wb_reg;
		logic [NREGS-1:0]  pending_mask;
		logic [1:0]        older_mem_ops;
		logic [7:0]        queue_space;
	} hz_info_t;

endpackage

// ----- src/rv32_decode_stage_with_hazards.sv -----
// Channel  Handshake            Payload
// -------  -------------------  ------------------------------------------------
// in       in_valid / in_ready  instr_word, pc, wb_*, ex_*, mem_*, older_mem_ops,
//                               pending_mask, queue_space
// out      out_valid/out_ready  operand_a/b, store_data, dest_reg, reg_write,
//                               alu_op, mem_op, stall_res, flush, target_pc,
//                               target_valid, illegal
//
// One request per clock while the output is not stalled; a result is registered
// after its request has passed through the first stage.
// The register file read at acceptance sets the first stage, decode and the
// target adders fill the second, which ends in the result register.
// Reset clears the register file through one valid flag per entry, at once.
// A stalled output holds its result while the input stage can still fill.
module rv32_decode_stage_with_hazards (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [rvdec_pkg::XLEN-1:0]            instr_word,
	input  logic [rvdec_pkg::XLEN-1:0]            pc,
	input  logic                                  wb_write,
	input  logic [rvdec_pkg::REG_AW-1:0]          wb_reg,
	input  logic signed [rvdec_pkg::XLEN-1:0]     wb_data,
	input  logic                                  ex_write,
	input  logic [rvdec_pkg::REG_AW-1:0]          ex_reg,
	input  logic                                  mem_write,
	input  logic [rvdec_pkg::REG_AW-1:0]          mem_reg,
	input  logic [1:0]                            older_mem_ops,
	input  logic [rvdec_pkg::NREGS-1:0]           pending_mask,
	input  logic [7:0]                            queue_space,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [rvdec_pkg::XLEN-1:0]     operand_a,
	output logic signed [rvdec_pkg::XLEN-1:0]     operand_b,
	output logic signed [rvdec_pkg::XLEN-1:0]     store_data,
	output logic [rvdec_pkg::REG_AW-1:0]          dest_reg,
	output logic                                  reg_write,
	output logic [4:0]                            alu_op,
	output logic [3:0]                            mem_op,
	output logic                                  stall_res,
	output logic                                  flush,
	output logic [rvdec_pkg::XLEN-1:0]            target_pc,
	output logic                                  target_valid,
	output logic                                  illegal
);
	import rvdec_pkg::*;

	logic [XLEN-1:0] rf_mem [NREGS];
	logic [NREGS-1:0] rf_vld_q;

	logic in_acc, adv_out;
	logic v_s1, v_s2;
	logic [XLEN-1:0] instr_s1, pc_s1, rd1_s1, rd2_s1;
	logic vld1_s1, vld2_s1;
	hz_info_t hz_s1;

	logic [XLEN-1:0] opa_s2, opb_s2, sdata_s2, target_s2;
	logic [REG_AW-1:0] dest_s2;
	logic [4:0] alu_s2;
	logic [3:0] mem_s2;
	logic wr_s2, stall_s2, jump_s2, tvalid_s2, illegal_s2;

	assign adv_out = !v_s2 || out_ready;
	assign in_ready = !v_s1 || adv_out;
	assign in_acc = in_valid && in_ready;

	// Register file: the read sees the contents before this request's writeback.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			rd1_s1 <= rf_mem[instr_word[19:15]];
			rd2_s1 <= rf_mem[instr_word[24:20]];
			if (wb_write && wb_reg != '0) begin
				rf_mem[wb_reg] <= wb_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
		end else if (in_acc && wb_write && wb_reg != '0) begin
			rf_vld_q[wb_reg] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			instr_s1 <= instr_word;
			pc_s1 <= pc;
			vld1_s1 <= rf_vld_q[instr_word[19:15]];
			vld2_s1 <= rf_vld_q[instr_word[24:20]];
			hz_s1.ex_write <= ex_write;
			hz_s1.ex_reg <= ex_reg;
			hz_s1.mem_write <= mem_write;
			hz_s1.mem_reg <= mem_reg;
			hz_s1.wb_write <= wb_write;
			hz_s1.wb_reg <= wb_reg;
			hz_s1.pending_mask <= pending_mask;
			hz_s1.older_mem_ops <= older_mem_ops;
			hz_s1.queue_space <= queue_space;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (adv_out) begin
				v_s2 <= v_s1;
			end
		end
	end

	// Decode
	logic [2:0] f3;
	logic [REG_AW-1:0] rd, ra1, ra2;
	logic [4:0] opc;
	logic [XLEN-1:0] rs1, rs2, imm12, imm_s, imm_u, off_j, off_b, pc_off, pc_tgt, jalr_sum;
	logic [XLEN-1:0] d_opa, d_opb, d_sdata, d_target;
	logic [REG_AW-1:0] d_dest;
	logic [4:0] d_alu;
	logic [3:0] d_mem;
	logic d_wr, d_use1, d_use2, d_jump, d_tvalid, d_illegal, d_memop;
	logic [2:0] mem_count;
	logic qfull, stall;

	function automatic logic hz_on(input logic [REG_AW-1:0] r, input hz_info_t h);
		logic hit;
		hit = (h.ex_write && h.ex_reg == r) || (h.mem_write && h.mem_reg == r)
			|| (h.wb_write && h.wb_reg == r) || h.pending_mask[r];
		return (r != '0) && hit;
	endfunction

	assign f3 = instr_s1[14:12];
	assign rd = instr_s1[11:7];
	assign ra1 = instr_s1[19:15];
	assign ra2 = instr_s1[24:20];
	assign opc = instr_s1[6:2];
	assign rs1 = vld1_s1 ? rd1_s1 : '0;
	assign rs2 = vld2_s1 ? rd2_s1 : '0;

	assign imm12 = {{20{instr_s1[31]}}, instr_s1[31:20]};
	assign imm_s = {{20{instr_s1[31]}}, instr_s1[31:25], instr_s1[11:7]};
	assign imm_u = {instr_s1[31:12], 12'b0};
	assign off_j = {{11{instr_s1[31]}}, instr_s1[31], instr_s1[19:12], instr_s1[20],
		instr_s1[30:21], 1'b0};
	assign off_b = {{19{instr_s1[31]}}, instr_s1[31], instr_s1[7], instr_s1[30:25],
		instr_s1[11:8], 1'b0};
	assign pc_off = (opc == OPC_JAL) ? off_j : off_b;
	assign pc_tgt = pc_s1 + pc_off;
	assign jalr_sum = rs1 + imm12;

	always_comb begin
		d_opa = '0;
		d_opb = '0;
		d_sdata = rs2;
		d_dest = '0;
		d_alu = ALU_ADD;
		d_mem = MEM_NONE;
		d_target = '0;
		d_wr = 1'b0;
		d_use1 = 1'b0;
		d_use2 = 1'b0;
		d_jump = 1'b0;
		d_tvalid = 1'b0;
		d_illegal = 1'b0;
		d_memop = 1'b0;
		unique case (opc)
			OPC_LOAD: begin
				d_opa = rs1;
				d_opb = imm12;
				d_dest = rd;
				d_wr = 1'b1;
				d_mem = {1'b0, f3};
				d_use1 = 1'b1;
				d_memop = 1'b1;
			end
			OPC_STORE: begin
				d_opa = rs1;
				d_opb = imm_s;
				d_dest = rd;
				d_mem = {1'b0, f3} | STORE_FLAG;
				d_use1 = 1'b1;
				d_use2 = 1'b1;
				d_memop = 1'b1;
			end
			OPC_OPIMM: begin
				d_opa = rs1;
				d_opb = imm12;
				d_dest = rd;
				d_wr = 1'b1;
				d_alu = {1'b0, (f3 == F3_SLL || f3 == F3_SRX) && instr_s1[30], f3};
				d_use1 = 1'b1;
			end
			OPC_OP: begin
				d_opa = rs1;
				d_opb = rs2;
				d_dest = rd;
				d_wr = 1'b1;
				d_alu = {instr_s1[25], instr_s1[30], f3};
				d_use1 = 1'b1;
				d_use2 = 1'b1;
			end
			OPC_LUI: begin
				d_opb = imm_u;
				d_dest = rd;
				d_wr = 1'b1;
				d_alu = ALU_OR;
			end
			OPC_AUIPC: begin
				d_opa = pc_s1;
				d_opb = imm_u;
				d_dest = rd;
				d_wr = 1'b1;
			end
			OPC_JAL: begin
				d_target = pc_tgt;
				d_tvalid = 1'b1;
				d_jump = 1'b1;
				d_opa = pc_s1;
				d_opb = LINK_STEP;
				d_dest = rd;
				d_wr = 1'b1;
			end
			OPC_JALR: begin
				d_target = {jalr_sum[XLEN-1:1], 1'b0};
				d_tvalid = 1'b1;
				d_jump = 1'b1;
				d_opa = pc_s1;
				d_opb = LINK_STEP;
				d_dest = rd;
				d_wr = 1'b1;
				d_use1 = 1'b1;
			end
			OPC_BRANCH: begin
				d_target = pc_tgt;
				d_tvalid = 1'b1;
				d_opa = rs1;
				d_opb = rs2;
				d_use1 = 1'b1;
				d_use2 = 1'b1;
				unique case (f3)
					F3_BEQ: d_jump = (rs1 == rs2);
					F3_BNE: d_jump = (rs1 != rs2);
					F3_BLT: d_jump = ($signed(rs1) < $signed(rs2));
					F3_BGE: d_jump = ($signed(rs1) >= $signed(rs2));
					F3_BLTU: d_jump = (rs1 < rs2);
					F3_BGEU: d_jump = (rs1 >= rs2);
					default: d_illegal = 1'b1;
				endcase
			end
			OPC_FENCE, OPC_SYSTEM: begin
				d_opa = DEAD_VALUE;
				d_opb = DEAD_VALUE;
				d_sdata = DEAD_VALUE;
				d_dest = SYS_DEST;
			end
			default: begin
				d_illegal = 1'b1;
				d_sdata = '0;
			end
		endcase
	end

	// The count may reach four when older_mem_ops is three and this request is a memory operation.
	assign mem_count = {2'b0, d_memop} + {1'b0, hz_s1.older_mem_ops};
	assign qfull = hz_s1.queue_space < {5'b0, mem_count};
	assign stall = (d_use1 && hz_on(ra1, hz_s1)) || (d_use2 && hz_on(ra2, hz_s1)) || qfull;

	always_ff @(posedge clk) begin
		if (adv_out && v_s1) begin
			opa_s2 <= d_opa;
			opb_s2 <= d_opb;
			sdata_s2 <= d_sdata;
			dest_s2 <= d_dest;
			illegal_s2 <= d_illegal;
			stall_s2 <= stall;
			priority if (stall) begin
				alu_s2 <= ALU_ADD;
				mem_s2 <= MEM_NONE;
				wr_s2 <= 1'b0;
				jump_s2 <= 1'b0;
				target_s2 <= pc_s1;
				tvalid_s2 <= 1'b1;
			end else if (d_jump) begin
				alu_s2 <= ALU_ADD;
				mem_s2 <= MEM_NONE;
				wr_s2 <= d_wr;
				jump_s2 <= 1'b1;
				target_s2 <= d_target;
				tvalid_s2 <= d_tvalid;
			end else begin
				alu_s2 <= d_alu;
				mem_s2 <= d_mem;
				wr_s2 <= d_wr;
				jump_s2 <= 1'b0;
				target_s2 <= d_target;
				tvalid_s2 <= d_tvalid;
			end
		end
	end

	assign out_valid = v_s2;
	assign operand_a = opa_s2;
	assign operand_b = opb_s2;
	assign store_data = sdata_s2;
	assign dest_reg = dest_s2;
	assign reg_write = wr_s2;
	assign alu_op = alu_s2;
	assign mem_op = mem_s2;
	assign stall_res = stall_s2;
	assign flush = jump_s2;
	assign target_pc = target_s2;
	assign target_valid = tvalid_s2;
	assign illegal = illegal_s2;

endmodule

// ----- src/rvdec_checker.sv -----
`include "rv32_decode_stage_with_hazards_macros.svh"

module rvdec_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [rvdec_pkg::XLEN-1:0]         operand_a,
	input logic [rvdec_pkg::XLEN-1:0]         target_pc,
	input logic [rvdec_pkg::REG_AW-1:0]       dest_reg,
	input logic                               reg_write,
	input logic [4:0]                         alu_op,
	input logic [3:0]                         mem_op,
	input logic                               stall_res,
	input logic                               flush,
	input logic                               target_valid,
	input logic                               illegal
);
	import rvdec_pkg::*;

	// A result held under backpressure keeps its contents.
	`RVDEC_CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(operand_a) && $stable(target_pc) && $stable(dest_reg))

	// A stalled request becomes a bubble that still redirects to its own pc.
	`RVDEC_CHK_NOW(a_stall_nop, out_valid && stall_res, !reg_write && !flush && target_valid && alu_op == ALU_ADD && mem_op == MEM_NONE)

	// A taken jump or branch carries a target and no ALU or memory work.
	`RVDEC_CHK_NOW(a_flush_tgt, out_valid && flush, target_valid && !stall_res && alu_op == ALU_ADD && mem_op == MEM_NONE)

	// An illegal instruction never writes a register.
	`RVDEC_CHK_NOW(a_illegal_nowr, out_valid && illegal, !reg_write)

endmodule

bind rv32_decode_stage_with_hazards rvdec_checker u_rvdec_checker (.*);

// ----- dv/decode_check_pkg.sv -----
package decode_check_pkg;

	import rvdec_pkg::*;

	typedef struct packed {
		logic [XLEN-1:0]   instr_word;
		logic [XLEN-1:0]   pc;
		logic              wb_write;
		logic [REG_AW-1:0] wb_reg;
		logic [XLEN-1:0]   wb_data;
		logic              ex_write;
		logic [REG_AW-1:0] ex_reg;
		logic              mem_write;
		logic [REG_AW-1:0] mem_reg;
		logic [1:0]        older_mem_ops;
		logic [NREGS-1:0]  pending_mask;
		logic [7:0]        queue_space;
	} decode_req_t;

	typedef struct packed {
		logic [XLEN-1:0]   operand_a;
		logic [XLEN-1:0]   operand_b;
		logic [XLEN-1:0]   store_data;
		logic [REG_AW-1:0] dest_reg;
		logic              reg_write;
		logic [4:0]        alu_op;
		logic [3:0]        mem_op;
		logic              stall_res;
		logic              flush;
		logic [XLEN-1:0]   target_pc;
		logic              target_valid;
		logic              illegal;
	} decode_res_t;

	class decode_scoreboard;
		logic [XLEN-1:0] regs [NREGS];
		decode_res_t predicted_decodes [$];
		int unsigned errors;
		int unsigned checked;
		int unsigned stalls;
		int unsigned redirects;
		int unsigned illegals;

		function new();
			foreach (regs[i]) regs[i] = '0;
			errors = 0;
			checked = 0;
			stalls = 0;
			redirects = 0;
			illegals = 0;
		endfunction

		function bit reg_busy(logic [REG_AW-1:0] idx, decode_req_t r);
			if (idx == '0)
				return 1'b0;
			return (r.ex_write && r.ex_reg == idx) || (r.mem_write && r.mem_reg == idx) ||
				(r.wb_write && r.wb_reg == idx) || r.pending_mask[idx];
		endfunction

		// Decodes one request against the current register file, then applies its writeback.
		function decode_res_t decode_instr(decode_req_t r);
			decode_res_t d;
			logic [XLEN-1:0] ins;
			logic [XLEN-1:0] rs1v;
			logic [XLEN-1:0] rs2v;
			logic [XLEN-1:0] imm_i;
			logic [XLEN-1:0] jump_sum;
			logic [4:0] opc;
			logic [REG_AW-1:0] s1;
			logic [REG_AW-1:0] s2;
			logic [2:0] f3;
			logic [2:0] mem_count;
			logic use1;
			logic use2;
			logic jump;
			logic memop;
			logic stall;
			ins = r.instr_word;
			opc = ins[6:2];
			f3 = ins[14:12];
			s1 = ins[19:15];
			s2 = ins[24:20];
			rs1v = regs[s1];
			rs2v = regs[s2];
			imm_i = {{20{ins[31]}}, ins[31:20]};
			d = '0;
			d.store_data = rs2v;
			d.mem_op = MEM_NONE;
			use1 = 1'b0;
			use2 = 1'b0;
			jump = 1'b0;
			memop = 1'b0;
			case (opc)
				OPC_LOAD: begin
					d.operand_a = rs1v;
					d.operand_b = imm_i;
					d.dest_reg = ins[11:7];
					d.reg_write = 1'b1;
					d.alu_op = ALU_ADD;
					d.mem_op = {1'b0, f3};
					use1 = 1'b1;
					memop = 1'b1;
				end
				OPC_STORE: begin
					d.operand_a = rs1v;
					d.operand_b = {{20{ins[31]}}, ins[31:25], ins[11:7]};
					d.dest_reg = ins[11:7];
					d.alu_op = ALU_ADD;
					d.mem_op = STORE_FLAG | {1'b0, f3};
					use1 = 1'b1;
					use2 = 1'b1;
					memop = 1'b1;
				end
				OPC_OPIMM: begin
					d.operand_a = rs1v;
					d.operand_b = imm_i;
					d.dest_reg = ins[11:7];
					d.reg_write = 1'b1;
					d.alu_op = {2'b00, f3};
					if (f3 == F3_SLL || f3 == F3_SRX)
						d.alu_op[3] = ins[30];
					use1 = 1'b1;
				end
				OPC_OP: begin
					d.operand_a = rs1v;
					d.operand_b = rs2v;
					d.dest_reg = ins[11:7];
					d.reg_write = 1'b1;
					d.alu_op = {ins[25], ins[30], f3};
					use1 = 1'b1;
					use2 = 1'b1;
				end
				OPC_LUI: begin
					d.operand_a = '0;
					d.operand_b = {ins[31:12], 12'h000};
					d.dest_reg = ins[11:7];
					d.reg_write = 1'b1;
					d.alu_op = ALU_OR;
				end
				OPC_AUIPC: begin
					d.operand_a = r.pc;
					d.operand_b = {ins[31:12], 12'h000};
					d.dest_reg = ins[11:7];
					d.reg_write = 1'b1;
					d.alu_op = ALU_ADD;
				end
				OPC_JAL: begin
					d.target_pc = r.pc + {{11{ins[31]}}, ins[31], ins[19:12], ins[20],
						ins[30:21], 1'b0};
					d.target_valid = 1'b1;
					jump = 1'b1;
					d.operand_a = r.pc;
					d.operand_b = LINK_STEP;
					d.dest_reg = ins[11:7];
					d.reg_write = 1'b1;
					d.alu_op = ALU_ADD;
				end
				OPC_JALR: begin
					jump_sum = rs1v + imm_i;
					d.target_pc = {jump_sum[XLEN-1:1], 1'b0};
					d.target_valid = 1'b1;
					jump = 1'b1;
					d.operand_a = r.pc;
					d.operand_b = LINK_STEP;
					d.dest_reg = ins[11:7];
					d.reg_write = 1'b1;
					d.alu_op = ALU_ADD;
					use1 = 1'b1;
				end
				OPC_BRANCH: begin
					d.target_pc = r.pc + {{19{ins[31]}}, ins[31], ins[7], ins[30:25],
						ins[11:8], 1'b0};
					d.target_valid = 1'b1;
					d.operand_a = rs1v;
					d.operand_b = rs2v;
					case (f3)
						F3_BEQ: jump = (rs1v == rs2v);
						F3_BNE: jump = (rs1v != rs2v);
						F3_BLT: jump = ($signed(rs1v) < $signed(rs2v));
						F3_BGE: jump = ($signed(rs1v) >= $signed(rs2v));
						F3_BLTU: jump = (rs1v < rs2v);
						F3_BGEU: jump = (rs1v >= rs2v);
						default: d.illegal = 1'b1;
					endcase
					use1 = 1'b1;
					use2 = 1'b1;
				end
				OPC_FENCE, OPC_SYSTEM: begin
					d.operand_a = DEAD_VALUE;
					d.operand_b = DEAD_VALUE;
					d.store_data = DEAD_VALUE;
					d.dest_reg = SYS_DEST;
				end
				default: begin
					d.illegal = 1'b1;
					d.store_data = '0;
				end
			endcase

			mem_count = {2'b00, memop} + {1'b0, r.older_mem_ops};
			stall = (use1 && reg_busy(s1, r)) || (use2 && reg_busy(s2, r)) ||
				(r.queue_space < {5'b00000, mem_count});
			if (stall) begin
				d.alu_op = '0;
				d.mem_op = MEM_NONE;
				d.reg_write = 1'b0;
				jump = 1'b0;
				d.target_pc = r.pc;
				d.target_valid = 1'b1;
			end else if (jump) begin
				d.alu_op = '0;
				d.mem_op = MEM_NONE;
			end
			d.stall_res = stall;
			d.flush = jump;

			// The writeback lands after the read, so this request never sees its own data.
			if (r.wb_write && r.wb_reg != '0)
				regs[r.wb_reg] = r.wb_data;
			return d;
		endfunction

		function void note_request(decode_req_t r);
			predicted_decodes.push_back(decode_instr(r));
		endfunction

		function void compare_field(string name, logic [XLEN-1:0] exp, logic [XLEN-1:0] act);
			if (exp !== act) begin
				$error("%s: expected %h, got %h", name, exp, act);
				errors++;
			end
		endfunction

		function void check_result(decode_res_t got);
			decode_res_t exp;
			if (predicted_decodes.size() == 0) begin
				$error("decode result arrived with no request outstanding");
				errors++;
				return;
			end
			exp = predicted_decodes.pop_front();
			checked++;
			if (exp.stall_res)
				stalls++;
			if (exp.flush)
				redirects++;
			if (exp.illegal)
				illegals++;
			compare_field("operand_a", exp.operand_a, got.operand_a);
			compare_field("operand_b", exp.operand_b, got.operand_b);
			compare_field("store_data", exp.store_data, got.store_data);
			compare_field("dest_reg", XLEN'(exp.dest_reg), XLEN'(got.dest_reg));
			compare_field("reg_write", XLEN'(exp.reg_write), XLEN'(got.reg_write));
			compare_field("alu_op", XLEN'(exp.alu_op), XLEN'(got.alu_op));
			compare_field("mem_op", XLEN'(exp.mem_op), XLEN'(got.mem_op));
			compare_field("stall_res", XLEN'(exp.stall_res), XLEN'(got.stall_res));
			compare_field("flush", XLEN'(exp.flush), XLEN'(got.flush));
			compare_field("target_pc", exp.target_pc, got.target_pc);
			compare_field("target_valid", XLEN'(exp.target_valid), XLEN'(got.target_valid));
			compare_field("illegal", XLEN'(exp.illegal), XLEN'(got.illegal));
		endfunction

		function int outstanding();
			return predicted_decodes.size();
		endfunction
	endclass

endpackage

// ----- dv/testbench.sv -----
module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	import rvdec_pkg::*;
	import decode_check_pkg::*;

	localparam logic [XLEN-1:0] NOP_WORD = 32'h0000_0013;
	localparam int RANDOM_ITEMS = 750;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic [XLEN-1:0]          instr_word;
	logic [XLEN-1:0]          pc;
	logic                     wb_write;
	logic [REG_AW-1:0]        wb_reg;
	logic signed [XLEN-1:0]   wb_data;
	logic                     ex_write;
	logic [REG_AW-1:0]        ex_reg;
	logic                     mem_write;
	logic [REG_AW-1:0]        mem_reg;
	logic [1:0]               older_mem_ops;
	logic [NREGS-1:0]         pending_mask;
	logic [7:0]               queue_space;
	logic                     out_valid;
	logic                     out_ready;
	logic signed [XLEN-1:0]   operand_a;
	logic signed [XLEN-1:0]   operand_b;
	logic signed [XLEN-1:0]   store_data;
	logic [REG_AW-1:0]        dest_reg;
	logic                     reg_write;
	logic [4:0]               alu_op;
	logic [3:0]               mem_op;
	logic                     stall_res;
	logic                     flush;
	logic [XLEN-1:0]          target_pc;
	logic                     target_valid;
	logic                     illegal;

	decode_scoreboard sb = new();

	logic [4:0] legal_opc [11] = '{OPC_LOAD, OPC_FENCE, OPC_OPIMM, OPC_AUIPC, OPC_STORE,
		OPC_OP, OPC_LUI, OPC_BRANCH, OPC_JALR, OPC_JAL, OPC_SYSTEM};
	logic [XLEN-1:0] corner_data [5] = '{32'h0000_0000, 32'h0000_0001, 32'hffff_ffff,
		32'h8000_0000, 32'h7fff_ffff};

	rv32_decode_stage_with_hazards uut (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic logic [XLEN-1:0] encode(logic [6:0] hi7, logic [4:0] f_rs2,
		logic [4:0] f_rs1, logic [2:0] f3, logic [4:0] f_rd, logic [4:0] opc);
		return {hi7, f_rs2, f_rs1, f3, f_rd, opc, 2'b11};
	endfunction

	function automatic decode_req_t plain_request(logic [XLEN-1:0] ins, logic [XLEN-1:0] addr);
		decode_req_t r;
		r = '0;
		r.instr_word = ins;
		r.pc = addr;
		r.queue_space = 8'd255;
		return r;
	endfunction

	function automatic logic [REG_AW-1:0] pick_reg();
		return ($urandom_range(0, 9) < 6) ? REG_AW'($urandom_range(0, 7)) :
			REG_AW'($urandom_range(0, 31));
	endfunction

	task automatic push_request(input decode_req_t r, input bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		instr_word <= r.instr_word;
		pc <= r.pc;
		wb_write <= r.wb_write;
		wb_reg <= r.wb_reg;
		wb_data <= r.wb_data;
		ex_write <= r.ex_write;
		ex_reg <= r.ex_reg;
		mem_write <= r.mem_write;
		mem_reg <= r.mem_reg;
		older_mem_ops <= r.older_mem_ops;
		pending_mask <= r.pending_mask;
		queue_space <= r.queue_space;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.note_request(r);
	endtask

	// Result side: takes each result, then may hold ready low for a random stretch.
	initial begin
		decode_res_t got;
		int stall_len;
		int taken;
		taken = 0;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		out_ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got = {operand_a, operand_b, store_data, dest_reg, reg_write, alu_op, mem_op,
					stall_res, flush, target_pc, target_valid, illegal};
				sb.check_result(got);
				taken++;
				stall_len = ((taken / 40) % 4 == 2) ? 0 : $urandom_range(0, 19);
				if (stall_len > 0) begin
					out_ready <= 1'b0;
					repeat (stall_len) @(posedge clk);
					out_ready <= 1'b1;
				end
			end
		end
	end

	initial begin
		decode_req_t r;
		logic [XLEN-1:0] ins;
		int sel;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		instr_word <= '0;
		pc <= '0;
		wb_write <= 1'b0;
		wb_reg <= '0;
		wb_data <= '0;
		ex_write <= 1'b0;
		ex_reg <= '0;
		mem_write <= 1'b0;
		mem_reg <= '0;
		older_mem_ops <= '0;
		pending_mask <= '0;
		queue_space <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Seed x1 and x2 with the signed extremes, and try a write to x0.
		r = plain_request(NOP_WORD, 32'h0);
		r.wb_write = 1'b1;
		r.wb_reg = 5'd1;
		r.wb_data = 32'h7fff_ffff;
		push_request(r, 1'b0);
		r = plain_request(NOP_WORD, 32'h4);
		r.wb_write = 1'b1;
		r.wb_reg = 5'd2;
		r.wb_data = 32'h8000_0000;
		push_request(r, 1'b0);
		r = plain_request(encode(7'h7f, 5'h1f, 5'd1, 3'd0, 5'd3, OPC_OPIMM), 32'h8);
		r.wb_write = 1'b1;
		r.wb_reg = 5'd0;
		r.wb_data = 32'h1234_5678;
		push_request(r, 1'b0);
		push_request(plain_request(encode(7'h20, 5'd31, 5'd2, F3_SRX, 5'd4, OPC_OPIMM),
			32'hc), 1'b0);
		push_request(plain_request(encode(7'h20, 5'd2, 5'd1, 3'd0, 5'd5, OPC_OP), 32'h10), 1'b0);
		push_request(plain_request(encode(7'h01, 5'd2, 5'd1, 3'd3, 5'd6, OPC_OP), 32'h14), 1'b0);
		r = plain_request(encode(7'h40, 5'd0, 5'd1, 3'd2, 5'd7, OPC_LOAD), 32'h18);
		r.older_mem_ops = 2'd2;
		r.queue_space = 8'd3;
		push_request(r, 1'b0);
		push_request(plain_request(encode(7'h7f, 5'd2, 5'd1, 3'd1, 5'h10, OPC_STORE), 32'h1c),
			1'b0);
		push_request(plain_request(encode(7'h55, 5'h0a, 5'h15, 3'd5, 5'd8, OPC_LUI), 32'h20),
			1'b0);
		push_request(plain_request(encode(7'h7f, 5'h1f, 5'h1f, 3'd7, 5'd9, OPC_AUIPC),
			32'hffff_f000), 1'b0);
		push_request(plain_request(encode(7'h7f, 5'h1f, 5'h1f, 3'd7, 5'd1, OPC_JAL), 32'h0),
			1'b0);
		push_request(plain_request(encode(7'h00, 5'd0, 5'd1, 3'd0, 5'd10, OPC_JALR), 32'h100),
			1'b0);
		// Every branch condition, the two undefined ones included, on a backward target.
		for (int f = 0; f < 8; f++)
			push_request(plain_request(encode(7'h40, 5'd2, 5'd1, 3'(f), 5'd3, OPC_BRANCH),
				32'h1000), 1'b0);
		push_request(plain_request(encode(7'h0f, 5'd3, 5'd4, 3'd0, 5'd5, OPC_FENCE), 32'h24),
			1'b0);
		push_request(plain_request(encode(7'h00, 5'd1, 5'd0, 3'd0, 5'd0, OPC_SYSTEM), 32'h28),
			1'b0);
		push_request(plain_request(encode(7'h12, 5'd3, 5'd4, 3'd5, 5'd6, 5'd31), 32'h2c), 1'b0);
		r = plain_request(encode(7'h20, 5'd2, 5'd1, 3'd0, 5'd5, OPC_OP), 32'h30);
		r.ex_write = 1'b1;
		r.ex_reg = 5'd2;
		push_request(r, 1'b0);
		r = plain_request(encode(7'h40, 5'd0, 5'd1, 3'd2, 5'd7, OPC_LOAD), 32'h34);
		r.pending_mask = 32'h0000_0002;
		push_request(r, 1'b0);
		r = plain_request(encode(7'h7f, 5'd2, 5'd1, 3'd1, 5'h10, OPC_STORE), 32'h38);
		r.older_mem_ops = 2'd3;
		r.queue_space = 8'd3;
		push_request(r, 1'b0);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 2) begin
				in_valid <= 1'b0;
				while (sb.outstanding() != 0) @(posedge clk);
			end
			sel = $urandom_range(0, 99);
			ins = $urandom;
			ins[6:2] = (sel < 8) ? 5'($urandom_range(0, 31)) : legal_opc[$urandom_range(0, 10)];
			if ($urandom_range(0, 9) != 0)
				ins[1:0] = 2'b11;
			if ($urandom_range(0, 9) < 7)
				ins[19:15] = 5'($urandom_range(0, 7));
			if ($urandom_range(0, 9) < 7)
				ins[24:20] = 5'($urandom_range(0, 7));
			r = '0;
			r.instr_word = ins;
			r.pc = $urandom;
			r.wb_write = ($urandom_range(0, 9) < 6);
			r.wb_reg = pick_reg();
			r.wb_data = ($urandom_range(0, 3) == 0) ? corner_data[$urandom_range(0, 4)] : $urandom;
			r.ex_write = 1'($urandom_range(0, 1));
			r.ex_reg = pick_reg();
			r.mem_write = 1'($urandom_range(0, 1));
			r.mem_reg = pick_reg();
			r.older_mem_ops = 2'($urandom_range(0, 3));
			sel = $urandom_range(0, 19);
			if (sel < 15)
				r.pending_mask = '0;
			else if (sel < 19)
				r.pending_mask = 32'h1 << $urandom_range(0, 31);
			else
				r.pending_mask = $urandom;
			r.queue_space = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 4)) :
				8'($urandom_range(0, 255));
			push_request(r, (n / 60) % 3 == 1);
		end
		in_valid <= 1'b0;

		while (sb.outstanding() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("Checked %0d decode results over directed and random instructions:",
			sb.checked);
		$display("  %0d held by hazards or queue space, %0d redirects, %0d illegal.",
			sb.stalls, sb.redirects, sb.illegals);
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+src
src/rvdec_pkg.sv
src/rv32_decode_stage_with_hazards.sv
src/rvdec_checker.sv
dv/decode_check_pkg.sv
dv/testbench.sv
